@@ rtl/pdc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared widths, codes and types of the Pareto dominance comparator.
// ----------------------------------------------------------------------------
package pdc_pkg;

	localparam int ObjW      = 32;  // signed Q16.16 objective
	localparam int EpsW      = 31;  // unsigned Q15.16 epsilon
	localparam int ViolW     = 32;  // unsigned Q16.16 constraint violation
	localparam int ModeW     = 2;
	localparam int TolW      = 31;  // unsigned Q15.16 tolerance
	localparam int VerdW     = 2;
	localparam int CmpW      = ObjW + 2;  // room for a sum or difference, no overflow
	localparam int InDataW   = 160;
	localparam int OutDataW  = 8;
	localparam int ApbAddrW  = 3;
	localparam int ApbDataW  = 32;

	// compare modes; the unused code behaves as MODE_CON_EPS
	localparam logic [ModeW-1:0] MODE_TOL     = 2'd0;
	localparam logic [ModeW-1:0] MODE_CON_TOL = 2'd1;
	localparam logic [ModeW-1:0] MODE_CON_EPS = 2'd2;

	// verdict codes
	localparam logic [VerdW-1:0] VERDICT_NONE = 2'd0;
	localparam logic [VerdW-1:0] VERDICT_A    = 2'd1;
	localparam logic [VerdW-1:0] VERDICT_B    = 2'd2;

	// register word indexes
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_TOL  = 1'b1;

	typedef struct packed {
		logic a_ok;
		logic a_strict;
		logic b_ok;
		logic b_strict;
	} cmp_flags_t;

endpackage

@@ rtl/pareto_dominance_comparator_unit.sv @@
// ----------------------------------------------------------------------------
// pareto_dominance_comparator_unit
// Constrained Pareto dominance check of two candidates, one objective pair
// per transaction, with a verdict on the closing pair.
// ----------------------------------------------------------------------------
// Usage:
//   Stream the objective pairs of one comparison on the s_axis channel and
//   mark the final pair with s_axis_tlast; that pair also carries both
//   constraint violations. Exactly one verdict transaction leaves on m_axis
//   per comparison, none for the other pairs.
//   Set compare_mode (address 0) and tolerance (address 4) over APB while
//   the block is idle; pready is always high.
// Pipeline and throughput:
//   A pair is registered at acceptance, tested and folded into the running
//   flags in the next cycle; a verdict enters the output register as its
//   closing pair leaves the input register. One pair is taken every cycle
//   but for a stalled closing pair; the tests are four 34-bit input compares.
// Reset:
//   arst_n clears both pipeline valids, sets the flags to their idle state
//   (never worse set, strictly better clear) and mode and tolerance to zero.
// Stall:
//   While a verdict waits for m_axis_tready, pairs that are not last still
//   advance; a closing pair holds in the input register and s_axis_tready
//   drops until the waiting verdict is taken.
// ----------------------------------------------------------------------------
module pareto_dominance_comparator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// stream in
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// objective_a[31:0], objective_b[63:32], epsilon[94:64],
	// violation_a[126:95], violation_b[158:127], zero[159]
	input  logic [pdc_pkg::InDataW-1:0]       s_axis_tdata,
	input  logic                              s_axis_tlast,    // last_objective
	// stream out
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// verdict[1:0], zero[7:2]
	output logic [pdc_pkg::OutDataW-1:0]      m_axis_tdata,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pdc_pkg::ApbAddrW-1:0]      paddr,
	input  logic [pdc_pkg::ApbDataW-1:0]      pwdata,
	output logic [pdc_pkg::ApbDataW-1:0]      prdata,
	output logic                              pready
);
	import pdc_pkg::*;

	// configuration registers
	logic [ModeW-1:0] mode_q;
	logic [TolW-1:0]  tol_q;

	// input stage
	logic                    valid_s1;
	logic signed [ObjW-1:0]  obj_a_s1;
	logic signed [ObjW-1:0]  obj_b_s1;
	logic [EpsW-1:0]         eps_s1;
	logic [ViolW-1:0]        viol_a_s1;
	logic [ViolW-1:0]        viol_b_s1;
	logic                    last_s1;

	// running flags
	logic a_nw_q, a_sb_q, b_nw_q, b_sb_q;
	logic a_nw_nxt, a_sb_nxt, b_nw_nxt, b_sb_nxt;

	// output register
	logic             m_valid_q;
	logic [VerdW-1:0] verdict_q;
	logic [VerdW-1:0] verdict_nxt;

	cmp_flags_t cmp;
	logic       s_accept;
	logic       out_free;
	logic       adv_s1;
	logic       cfg_wr;
	logic       con_mode;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// word index is paddr[2]; byte offset bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TOL;
			tol_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MODE: mode_q <= pwdata[ModeW-1:0];
				default:  tol_q  <= pwdata[TolW-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {{(ApbDataW-ModeW){1'b0}}, mode_q};
			default:  prdata = {{(ApbDataW-TolW){1'b0}}, tol_q};
		endcase
	end

	// Handshake: a closing pair needs a free output register to advance.
	assign out_free      = !m_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the input stage, no reset
	always_ff @(posedge clk) begin
		if (s_accept) begin
			obj_a_s1  <= signed'(s_axis_tdata[31:0]);
			obj_b_s1  <= signed'(s_axis_tdata[63:32]);
			eps_s1    <= s_axis_tdata[94:64];
			viol_a_s1 <= s_axis_tdata[126:95];
			viol_b_s1 <= s_axis_tdata[158:127];
			last_s1   <= s_axis_tlast;
		end
	end

	// Mode bit 1 selects the epsilon rule, so the unused code acts as mode 2.
	pdc_objective_cmp u_cmp (
		.obj_a     (obj_a_s1),
		.obj_b     (obj_b_s1),
		.epsilon   (eps_s1),
		.tolerance (tol_q),
		.eps_mode  (mode_q[1]),
		.flags     (cmp)
	);

	// fold this pair into the flags
	assign a_nw_nxt = a_nw_q && cmp.a_ok;
	assign a_sb_nxt = a_sb_q || cmp.a_strict;
	assign b_nw_nxt = b_nw_q && cmp.b_ok;
	assign b_sb_nxt = b_sb_q || cmp.b_strict;

	assign con_mode = mode_q != MODE_TOL;

	// constraint first in constrained modes (smaller violation wins), then Pareto flags
	always_comb begin
		if (con_mode && (viol_a_s1 < viol_b_s1)) begin
			verdict_nxt = VERDICT_A;
		end else if (con_mode && (viol_a_s1 > viol_b_s1)) begin
			verdict_nxt = VERDICT_B;
		end else if (a_nw_nxt && a_sb_nxt) begin
			verdict_nxt = VERDICT_A;
		end else if (b_nw_nxt && b_sb_nxt) begin
			verdict_nxt = VERDICT_B;
		end else begin
			verdict_nxt = VERDICT_NONE;
		end
	end

	// return flags to idle after a closing pair, else advance them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_nw_q <= 1'b1;
			a_sb_q <= 1'b0;
			b_nw_q <= 1'b1;
			b_sb_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				a_nw_q <= 1'b1;
				a_sb_q <= 1'b0;
				b_nw_q <= 1'b1;
				b_sb_q <= 1'b0;
			end else begin
				a_nw_q <= a_nw_nxt;
				a_sb_q <= a_sb_nxt;
				b_nw_q <= b_nw_nxt;
				b_sb_q <= b_sb_nxt;
			end
		end
	end

	// output register: load on a closing pair, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			verdict_q <= verdict_nxt;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OutDataW-VerdW){1'b0}}, verdict_q};

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------

	// stall only for a closing pair behind an untaken verdict
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && last_s1 && m_valid_q && !m_axis_tready))
		else $error("input stalled without a waiting verdict");

	// a closing pair leaves the flags idle
	a_flags_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (a_nw_q && !a_sb_q && b_nw_q && !b_sb_q))
		else $error("flags not cleared after closing pair");

	// a verdict only follows a closing pair
	a_verdict_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(adv_s1 && last_s1))
		else $error("verdict without closing pair");

	// never the unused verdict code
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (verdict_q == VERDICT_NONE || verdict_q == VERDICT_A ||
			verdict_q == VERDICT_B))
		else $error("illegal verdict code");

endmodule

@@ rtl/pdc_objective_cmp.sv @@
// ----------------------------------------------------------------------------
// pdc_objective_cmp
// Per-objective tests for one A/B pair under tolerance or epsilon rules.
// ----------------------------------------------------------------------------
module pdc_objective_cmp (
	input  logic signed [pdc_pkg::ObjW-1:0] obj_a,
	input  logic signed [pdc_pkg::ObjW-1:0] obj_b,
	input  logic        [pdc_pkg::EpsW-1:0] epsilon,
	input  logic        [pdc_pkg::TolW-1:0] tolerance,
	input  logic                            eps_mode,
	output pdc_pkg::cmp_flags_t             flags
);
	import pdc_pkg::*;

	logic signed [CmpW-1:0] a_x;
	logic signed [CmpW-1:0] b_x;
	logic signed [CmpW-1:0] off_x;
	logic signed [CmpW-1:0] tol_x;
	logic signed [CmpW-1:0] b_plus_t;
	logic signed [CmpW-1:0] a_plus_t;
	logic signed [CmpW-1:0] b_minus_o;
	logic signed [CmpW-1:0] a_minus_o;

	assign a_x   = CmpW'(obj_a);
	assign b_x   = CmpW'(obj_b);
	assign tol_x = signed'({{(CmpW-TolW){1'b0}}, tolerance});
	// epsilon and tolerance share the strict-test subtractor
	assign off_x = eps_mode ? signed'({{(CmpW-EpsW){1'b0}}, epsilon}) : tol_x;

	assign b_plus_t  = b_x + tol_x;
	assign a_plus_t  = a_x + tol_x;
	assign b_minus_o = b_x - off_x;
	assign a_minus_o = a_x - off_x;

	always_comb begin
		if (eps_mode) begin
			flags.a_ok     = a_x <= b_x;
			flags.a_strict = a_x < b_minus_o;
			flags.b_ok     = b_x <= a_x;
			flags.b_strict = b_x < a_minus_o;
		end else begin
			flags.a_ok     = a_x <= b_plus_t;
			flags.a_strict = a_x <= b_minus_o;
			flags.b_ok     = b_x <= a_plus_t;
			flags.b_strict = b_x <= a_minus_o;
		end
	end

endmodule

@@ bench/pdc_verdict_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdc_verdict_checker
// Watches the stream, output and APB channels of the comparator, folds every
// accepted objective pair into its own dominance flags and checks each verdict
// against the oldest one predicted.
// ----------------------------------------------------------------------------
module pdc_verdict_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	input  logic                         s_axis_tready,
	input  logic [pdc_pkg::InDataW-1:0]  s_axis_tdata,
	input  logic                         s_axis_tlast,
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	input  logic [pdc_pkg::OutDataW-1:0] m_axis_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pdc_pkg::ApbAddrW-1:0] paddr,
	input  logic [pdc_pkg::ApbDataW-1:0] pwdata,
	input  logic                         pready,
	output int                           fail_cnt,
	output int                           verdicts_due
);
	import pdc_pkg::*;

	localparam int OB_LO = ObjW;
	localparam int EP_LO = 2 * ObjW;
	localparam int VA_LO = EP_LO + EpsW;
	localparam int VB_LO = VA_LO + ViolW;

	logic [ModeW-1:0] cmp_mode;
	logic [TolW-1:0]  tol;
	logic             a_keeps_up, a_ahead, b_keeps_up, b_ahead;
	logic [VerdW-1:0] verdict_q[$];
	logic [VerdW-1:0] want;

	// fold one pair into the running flags; close the comparison on the last pair
	task automatic fold_pair(input logic [InDataW-1:0] d, input logic last);
		longint           oa, ob, ep, tl;
		logic [ViolW-1:0] va, vb;
		cmp_flags_t       f;
		logic [VerdW-1:0] v;
		oa = longint'($signed(d[0 +: ObjW]));
		ob = longint'($signed(d[OB_LO +: ObjW]));
		ep = longint'(d[EP_LO +: EpsW]);
		va = d[VA_LO +: ViolW];
		vb = d[VB_LO +: ViolW];
		tl = longint'(tol);
		if ((cmp_mode & MODE_CON_EPS) != 0) begin
			f.a_ok     = oa <= ob;
			f.a_strict = oa < ob - ep;
			f.b_ok     = ob <= oa;
			f.b_strict = ob < oa - ep;
		end else begin
			f.a_ok     = oa <= ob + tl;
			f.a_strict = oa <= ob - tl;
			f.b_ok     = ob <= oa + tl;
			f.b_strict = ob <= oa - tl;
		end
		if (!f.a_ok)
			a_keeps_up = 1'b0;
		if (f.a_strict)
			a_ahead = 1'b1;
		if (!f.b_ok)
			b_keeps_up = 1'b0;
		if (f.b_strict)
			b_ahead = 1'b1;
		if (last) begin
			if (cmp_mode != MODE_TOL && va < vb)
				v = VERDICT_A;
			else if (cmp_mode != MODE_TOL && va > vb)
				v = VERDICT_B;
			else if (a_keeps_up && a_ahead)
				v = VERDICT_A;
			else if (b_keeps_up && b_ahead)
				v = VERDICT_B;
			else
				v = VERDICT_NONE;
			verdict_q.push_back(v);
			a_keeps_up = 1'b1;
			a_ahead    = 1'b0;
			b_keeps_up = 1'b1;
			b_ahead    = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_mode     = MODE_TOL;
			tol          = '0;
			a_keeps_up   = 1'b1;
			a_ahead      = 1'b0;
			b_keeps_up   = 1'b1;
			b_ahead      = 1'b0;
			verdict_q.delete();
			fail_cnt     = 0;
			verdicts_due = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_MODE)
					cmp_mode = pwdata[ModeW-1:0];
				else
					tol = pwdata[TolW-1:0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: verdict %0d with none expected", $time,
						m_axis_tdata[VerdW-1:0]);
					fail_cnt++;
				end else begin
					want = verdict_q.pop_front();
					if (m_axis_tdata[VerdW-1:0] !== want) begin
						$display("%0t: verdict mismatch, expected %0d, actual %0d", $time,
							want, m_axis_tdata[VerdW-1:0]);
						fail_cnt++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				fold_pair(s_axis_tdata, s_axis_tlast);
			verdicts_due = verdict_q.size();
		end
	end

endmodule

@@ bench/pareto_dominance_comparator_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pareto_dominance_comparator_unit_test
// Drives objective pairs into the comparator under every compare mode and a
// spread of tolerances, with random gaps on both streams and long output
// stalls; the verdict checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module pareto_dominance_comparator_unit_test;
	import pdc_pkg::*;

	localparam logic [ApbAddrW-1:0] ADDR_MODE = {REG_MODE, 2'b00};
	localparam logic [ApbAddrW-1:0] ADDR_TOL  = {REG_TOL, 2'b00};
	localparam logic [ModeW-1:0]    MODE_SPARE = 2'd3;  // unused code, acts as eps mode
	localparam logic [TolW-1:0]     TOL_MAX   = '1;
	localparam logic [EpsW-1:0]     EPS_MAX   = '1;
	localparam logic [ObjW-1:0]     OBJ_MIN   = 32'h8000_0000;
	localparam logic [ObjW-1:0]     OBJ_MAX   = 32'h7FFF_FFFF;
	localparam logic [ViolW-1:0]    VIOL_MAX  = '1;

	// which side a random comparison favors
	localparam int LEAN_A    = 0;
	localparam int LEAN_B    = 1;
	localparam int LEAN_NONE = 2;

	localparam int RAND_ITEMS    = 1050;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 250;  // long output stall, fills the block

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata;
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	int fail_cnt;
	int verdicts_due;
	int rand_items;
	int verdicts_taken;
	int tx_calm;
	int rx_calm;

	pareto_dominance_comparator_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	pdc_verdict_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_cnt      (fail_cnt),
		.verdicts_due  (verdicts_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs a handshake
	initial begin
		#5_000_000;
		$display("pareto_dominance_comparator_unit_test NOT OK");
		$finish;
	end

	// Draw a random wait; now and then start a calm stretch with no
	// waits at all so back-to-back transactions get exercised too.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 5);
	endfunction

	// Unsigned Q15.16 value for tolerance or epsilon: zero, full scale, a
	// small value that sits in the range of the objective steps, or anything.
	function automatic logic [EpsW-1:0] pick_q16();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return EPS_MAX;
			2: return EpsW'($urandom_range(1, 'h30000));
			default: return EpsW'($urandom);
		endcase
	endfunction

	// Distance between the two objectives; land on and around the threshold
	// often, since that is where the compares flip.
	function automatic longint pick_step(input longint near);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return near;
			2: return near + longint'($urandom_range(0, 2)) - 1;
			3: return longint'($urandom_range(0, 'h3FFFF));
			4: return -longint'($urandom_range(0, 'h3FFFF));
			default: return longint'($urandom);
		endcase
	endfunction

	function automatic logic [ObjW-1:0] clamp_obj(input longint v);
		if (v > longint'($signed(OBJ_MAX)))
			return OBJ_MAX;
		if (v < longint'($signed(OBJ_MIN)))
			return OBJ_MIN;
		return v[ObjW-1:0];
	endfunction

	function automatic logic [ObjW-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return OBJ_MIN;
			1: return OBJ_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// Offer one pair and hold it until the block takes it, then idle for a
	// drawn gap. Leave tvalid high on a zero gap so the next pair follows at once.
	task automatic send_pair(input logic [ObjW-1:0] oa, input logic [ObjW-1:0] ob,
			input logic [EpsW-1:0] eps, input logic [ViolW-1:0] va,
			input logic [ViolW-1:0] vb, input logic last);
		int gap;
		s_axis_tdata  <= {1'b0, vb, va, eps, ob, oa};
		s_axis_tlast  <= last;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Two-phase APB write; the register updates at the access edge. Idle after
	// it so back-to-back writes never overlap.
	task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Drop the stream, wait for every verdict in flight to come out, then
	// give the pipeline time to absorb pairs that produce no verdict.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		wait (verdicts_due == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [ModeW-1:0] mode, input logic [TolW-1:0] tol);
		settle();
		apb_write(ADDR_MODE, ApbDataW'(mode));
		apb_write(ADDR_TOL, ApbDataW'(tol));
	endtask

	// One random pair. Center on a shared base and push A above or below B by
	// a step near the active threshold so the flags really get exercised.
	task automatic random_pair(input logic [ModeW-1:0] mode, input logic [TolW-1:0] tol,
			input int lean, input logic last);
		logic [EpsW-1:0]  eps;
		longint           base, step, a;
		logic [ObjW-1:0]  oa, ob;
		logic [ViolW-1:0] va, vb;
		eps = pick_q16();
		if ($urandom_range(0, 2) == 0)
			base = longint'($signed($urandom));
		else
			base = longint'($urandom_range(0, 'h40000)) - 'h20000;
		step = pick_step((mode & MODE_CON_EPS) != 0 ? longint'(eps) : longint'(tol));
		if (lean == LEAN_A || (lean == LEAN_NONE && $urandom_range(0, 1) == 0))
			a = base - step;
		else
			a = base + step;
		oa = clamp_obj(a);
		ob = clamp_obj(base);
		if ($urandom_range(0, 15) == 0) begin
			oa = pick_extreme();
			ob = pick_extreme();
		end
		// equal violations push constrained modes onto the objective flags
		case ($urandom_range(0, 5))
			0, 1: begin
				va = $urandom;
				vb = va;
			end
			2: begin
				va = $urandom_range(0, 3);
				vb = $urandom_range(0, 3);
			end
			3: begin
				va = '0;
				vb = VIOL_MAX;
			end
			4: begin
				va = VIOL_MAX;
				vb = '0;
			end
			default: begin
				va = $urandom;
				vb = $urandom;
			end
		endcase
		send_pair(oa, ob, eps, va, vb, last);
		rand_items++;
	endtask

	// Output side: random back-pressure, plus two long holds while the
	// sender keeps offering so the block backs up and stalls its input.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		verdicts_taken = 0;
		rx_calm = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		m_axis_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				verdicts_taken++;
				if (verdicts_taken == 30 || verdicts_taken == 150)
					gap = HOLD_CYCLES;
				else
					gap = draw_gap(rx_calm);
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// Stimulus: directed corners first, then random phases of comparisons.
	initial begin
		logic [ModeW-1:0] mode;
		logic [TolW-1:0]  tol;
		int               phase, n_cmp, len, lean;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		rand_items    = 0;
		tx_calm       = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: plain tolerance dominance with zero tolerance
		send_pair('0, '0, '0, '0, '0, 1'b1);
		send_pair(OBJ_MIN, OBJ_MAX, EPS_MAX, '0, '0, 1'b0);
		send_pair(OBJ_MAX, OBJ_MIN, '0, '0, '0, 1'b1);
		// violations are ignored in mode 0
		send_pair('1, '0, '0, VIOL_MAX, '0, 1'b1);
		send_pair(OBJ_MAX, OBJ_MAX - 1, '0, '0, VIOL_MAX, 1'b1);

		// constraint first, then full-scale tolerance
		set_regs(MODE_CON_TOL, TOL_MAX);
		send_pair(OBJ_MIN, OBJ_MAX, '0, '0, VIOL_MAX, 1'b1);
		send_pair(OBJ_MIN, OBJ_MAX, '0, VIOL_MAX, '0, 1'b1);
		send_pair(OBJ_MAX, OBJ_MIN, '0, VIOL_MAX, VIOL_MAX, 1'b1);
		send_pair(32'd5, 32'd5, EPS_MAX, '0, '0, 1'b1);

		// constraint first, then epsilon dominance
		set_regs(MODE_CON_EPS, '0);
		send_pair(32'd1, 32'd2, '0, '0, '0, 1'b0);
		send_pair(32'd3, 32'd3, EPS_MAX, 32'd9, 32'd9, 1'b1);
		// mirror test for B's strict margin
		send_pair(32'd2, 32'd1, '0, '0, '0, 1'b1);
		send_pair(32'h1_0000, 32'h3_0000, 31'h2_0000, '0, '0, 1'b1);
		send_pair(32'h3_0000, 32'h1_0000, 31'h1_FFFF, '0, '0, 1'b1);

		// unused mode code behaves as epsilon mode
		set_regs(MODE_SPARE, 31'h1_0000);
		send_pair('0, 32'd1, '0, 32'd7, 32'd7, 1'b1);
		send_pair('0, 32'd1, '0, 32'd1, '0, 1'b1);

		// change mode in the middle of an open comparison
		send_pair('0, 32'd5, 31'd10, '0, '0, 1'b0);
		set_regs(MODE_TOL, '0);
		send_pair(32'd3, 32'd3, '0, 32'd1, 32'd2, 1'b1);

		phase = 0;
		while (rand_items < RAND_ITEMS) begin
			// walk every mode at the tolerance extremes first
			if (phase < 4) begin
				mode = phase[ModeW-1:0];
				tol  = phase[0] ? TOL_MAX : '0;
			end else begin
				mode = ModeW'($urandom_range(0, 3));
				tol  = pick_q16();
			end
			set_regs(mode, tol);
			n_cmp = $urandom_range(4, 16);
			repeat (n_cmp) begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(7, 14);
				else
					len = $urandom_range(1, 5);
				lean = $urandom_range(LEAN_A, LEAN_NONE);
				for (int i = 0; i < len; i++)
					random_pair(mode, tol, lean, i == len - 1);
			end
			// sometimes leave a comparison open across the next register write
			if ($urandom_range(0, 3) == 0) begin
				len = $urandom_range(1, 3);
				repeat (len) random_pair(mode, tol, LEAN_NONE, 1'b0);
			end
			phase++;
		end
		// close any comparison still open
		random_pair(mode, tol, LEAN_NONE, 1'b1);
		settle();

		if (fail_cnt == 0 && verdicts_due == 0)
			$display("pareto_dominance_comparator_unit_test OK");
		else
			$display("pareto_dominance_comparator_unit_test NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/pdc_pkg.sv
rtl/pdc_objective_cmp.sv
rtl/pareto_dominance_comparator_unit.sv
bench/pdc_verdict_checker.sv
bench/pareto_dominance_comparator_unit_test.sv
